>>> hdl/text_terminal_writer_core_defines.svh
// ----------------------------------------------------------------------------
// text terminal writer assertion macros
// shared concurrent check forms for the terminal writer core
// ----------------------------------------------------------------------------
`ifndef TEXT_TERMINAL_WRITER_CORE_DEFINES_SVH
`define TEXT_TERMINAL_WRITER_CORE_DEFINES_SVH

// implication in the same cycle, switched off while in reset
`define TTW_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("terminal writer check failed");

// implication on the following cycle, switched off while in reset
`define TTW_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("terminal writer check failed");

// implication on the following cycle, checked during reset as well
`define TTW_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("terminal writer check failed");

`endif

>>> hdl/ttw_pkg.sv
// ----------------------------------------------------------------------------
// ttw_pkg
// types and constants shared by the text terminal writer modules
// ----------------------------------------------------------------------------
package ttw_pkg;

   // screen geometry
   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int MOVE_COUNT = COLUMNS * (ROWS - 2);

   localparam int ADDR_W = $clog2(CELL_COUNT);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = $clog2(ROWS);

   // port field widths
   localparam int OP_W    = 2;
   localparam int CHAR_W  = 8;
   localparam int INDEX_W = 11;
   localparam int POS_W   = 11;
   localparam int COLOR_W = 8;
   localparam int CELL_W  = COLOR_W + CHAR_W;

   localparam logic [COLOR_W-1:0] COLOR_RESET  = 8'h07;
   localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'h0A;
   localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'h20;

   // request op codes
   localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   // command queue between front and back
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

   // classified command kinds
   typedef enum logic [2:0] {
      CMD_WRITE   = 3'd0,
      CMD_NEWLINE = 3'd1,
      CMD_CLEAR   = 3'd2,
      CMD_READ    = 3'd3,
      CMD_NOP     = 3'd4
   } ttw_cmd_kind_type;

   typedef struct packed {
      ttw_cmd_kind_type    kind;
      logic [CHAR_W-1:0]   char_code;
      logic [ADDR_W-1:0]   addr;
   } ttw_cmd_type;

   typedef struct packed {
      logic        valid;
      ttw_cmd_type cmd;
   } ttw_cmd_link_type;

endpackage

>>> hdl/text_terminal_writer_core.sv
// ----------------------------------------------------------------------------
// text_terminal_writer_core
// character cell text screen engine with cursor, wrap, scroll and clear
// ----------------------------------------------------------------------------
// usage: requests enter through a queue style port (req_push / req_full) and
// carry op, char_code and read_index. each request gives exactly one result,
// offered on the rsp_ ports while rsp_empty is low and taken with rsp_pop.
// the colour byte is written on csr_wdata with csr_valid; csr_ready is
// always high and the write should happen while the block is idle.
// a put, newline or unused op passes the command queue and then the result
// register, a read also the registered ram read; the single command sequencer
// takes a new request only while idle and its held result is absent or taken.
// a clear blanks all 80 x 25 = 2000 cells, one blank cell write per cycle.
// a put that reaches the last row scrolls: 1840 cells are copied up through the
// one read and one write port of the screen ram, then 160 blank writes.
// the command queue holds two requests; req_full rises when it is full.
// reset clears the cursor, queues and colour (back to 7); screen contents
// stay undefined until the first clear. when the receiver stalls, the held
// result waits and the sequencer stops, so req_full rises once the queue
// has filled up behind it.
// ----------------------------------------------------------------------------
`include "text_terminal_writer_core_defines.svh"

module text_terminal_writer_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [ttw_pkg::OP_W-1:0]      req_op,
   input  logic [ttw_pkg::CHAR_W-1:0]    req_char_code,
   input  logic [ttw_pkg::INDEX_W-1:0]   req_read_index,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [ttw_pkg::POS_W-1:0]     rsp_cursor_position,
   output logic                          rsp_cursor_moved,
   output logic [ttw_pkg::CELL_W-1:0]    rsp_cell_data,
   output logic                          rsp_read_valid,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ttw_pkg::COLOR_W-1:0]   csr_wdata
);

   logic [ttw_pkg::COLOR_W-1:0]   color_ff;
   ttw_pkg::ttw_cmd_link_type     cmd_link;
   logic                          cmd_take;

   // colour register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff <= ttw_pkg::COLOR_RESET;
      end else if (csr_valid && csr_ready) begin
         color_ff <= csr_wdata;
      end
   end

   // request front end
   ttw_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_op         (req_op),
      .req_char_code  (req_char_code),
      .req_read_index (req_read_index),
      .cmd_link       (cmd_link),
      .cmd_take       (cmd_take)
   );

   // execution back end
   ttw_back u_back (
      .clock               (clock),
      .reset               (reset),
      .text_color          (color_ff),
      .cmd_link            (cmd_link),
      .cmd_take            (cmd_take),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_cursor_position (rsp_cursor_position),
      .rsp_cursor_moved    (rsp_cursor_moved),
      .rsp_cell_data       (rsp_cell_data),
      .rsp_read_valid      (rsp_read_valid)
   );

   // checks
   `TTW_ASSERT_NEXT_ALWAYS(a_reset_not_full, clock, reset, !req_full && rsp_empty)
   `TTW_ASSERT_SAME(a_pos_in_range, clock, reset, !rsp_empty,
      32'(rsp_cursor_position) < ttw_pkg::CELL_COUNT)
   `TTW_ASSERT_SAME(a_read_no_move, clock, reset, !rsp_empty && rsp_read_valid,
      !rsp_cursor_moved)
   `TTW_ASSERT_SAME(a_data_only_read, clock, reset, !rsp_empty && !rsp_read_valid,
      rsp_cell_data == '0)

endmodule

>>> hdl/ttw_ram.sv
// ----------------------------------------------------------------------------
// ttw_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ttw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // storage and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/ttw_front.sv
// ----------------------------------------------------------------------------
// ttw_front
// accepts requests, classifies them and holds them in a short command queue
// ----------------------------------------------------------------------------
module ttw_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [ttw_pkg::OP_W-1:0]      req_op,
   input  logic [ttw_pkg::CHAR_W-1:0]    req_char_code,
   input  logic [ttw_pkg::INDEX_W-1:0]   req_read_index,
   output ttw_pkg::ttw_cmd_link_type     cmd_link,
   input  logic                          cmd_take
);

   ttw_pkg::ttw_cmd_type                 q_ff [ttw_pkg::CMDQ_DEPTH];
   logic [ttw_pkg::CMDQ_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [ttw_pkg::CMDQ_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [ttw_pkg::CMDQ_CNT_W-1:0]       count_ff, count_in;
   ttw_pkg::ttw_cmd_type                 cmd_new;
   logic                                 push_ok;
   logic                                 pop_ok;

   // classify the incoming request
   always_comb begin
      cmd_new.kind      = ttw_pkg::CMD_NOP;
      cmd_new.char_code = req_char_code;
      cmd_new.addr      = ttw_pkg::ADDR_W'(req_read_index);
      unique case (req_op)
         ttw_pkg::OP_PUT: begin
            if (req_char_code == ttw_pkg::NEWLINE_CODE) begin
               cmd_new.kind = ttw_pkg::CMD_NEWLINE;
            end else begin
               cmd_new.kind = ttw_pkg::CMD_WRITE;
            end
         end
         ttw_pkg::OP_CLEAR: begin
            cmd_new.kind = ttw_pkg::CMD_CLEAR;
         end
         ttw_pkg::OP_READ: begin
            // out of range index reports no data
            if (32'(req_read_index) < ttw_pkg::CELL_COUNT) begin
               cmd_new.kind = ttw_pkg::CMD_READ;
            end
         end
         default: begin
            cmd_new.kind = ttw_pkg::CMD_NOP;
         end
      endcase
   end

   assign req_full = (count_ff == ttw_pkg::CMDQ_CNT_W'(ttw_pkg::CMDQ_DEPTH));
   assign push_ok  = req_push && !req_full;
   assign pop_ok   = cmd_take && cmd_link.valid;

   // queue pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (32'(wr_ptr_ff) == ttw_pkg::CMDQ_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (32'(rd_ptr_ff) == ttw_pkg::CMDQ_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   assign cmd_link.valid = (count_ff != '0);
   assign cmd_link.cmd   = q_ff[rd_ptr_ff];

endmodule

>>> hdl/ttw_back.sv
// ----------------------------------------------------------------------------
// ttw_back
// executes commands on the screen store and cursor, holds the result
// ----------------------------------------------------------------------------
module ttw_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [ttw_pkg::COLOR_W-1:0]   text_color,
   input  ttw_pkg::ttw_cmd_link_type     cmd_link,
   output logic                          cmd_take,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [ttw_pkg::POS_W-1:0]     rsp_cursor_position,
   output logic                          rsp_cursor_moved,
   output logic [ttw_pkg::CELL_W-1:0]    rsp_cell_data,
   output logic                          rsp_read_valid
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_READ  = 4'b0010,
      ST_MOVE  = 4'b0100,
      ST_BLANK = 4'b1000
   } ttw_state_type;

   ttw_state_type                     state_ff, state_in;
   logic [ttw_pkg::COL_W-1:0]         col_ff, col_in;
   logic [ttw_pkg::ROW_W-1:0]         row_ff, row_in;
   logic [ttw_pkg::ADDR_W-1:0]        sweep_ff, sweep_in;
   logic                              mv_pend_ff, mv_pend_in;
   logic [ttw_pkg::ADDR_W-1:0]        mv_addr_ff, mv_addr_in;
   logic                              moved_ff, moved_in;

   logic                              rsp_valid_ff;
   logic [ttw_pkg::POS_W-1:0]         rsp_pos_ff;
   logic                              rsp_moved_ff;
   logic [ttw_pkg::CELL_W-1:0]        rsp_data_ff;
   logic                              rsp_rvalid_ff;

   logic                              rsp_load;
   logic                              rsp_moved_new;
   logic [ttw_pkg::CELL_W-1:0]        rsp_data_new;
   logic                              rsp_rvalid_new;

   logic                              ram_we;
   logic [ttw_pkg::ADDR_W-1:0]        ram_waddr;
   logic [ttw_pkg::CELL_W-1:0]        ram_wdata;
   logic [ttw_pkg::ADDR_W-1:0]        ram_raddr;
   logic [ttw_pkg::CELL_W-1:0]        ram_rdata;

   logic [ttw_pkg::COL_W:0]           col_inc;
   logic [ttw_pkg::ROW_W:0]           row_inc;
   logic                              row_step;
   logic [ttw_pkg::CELL_W-1:0]        blank_cell;

   function automatic logic [ttw_pkg::ADDR_W-1:0] cell_addr(
      input logic [ttw_pkg::ROW_W-1:0] row,
      input logic [ttw_pkg::COL_W-1:0] col
   );
      cell_addr = ttw_pkg::ADDR_W'(row) * ttw_pkg::ADDR_W'(ttw_pkg::COLUMNS)
                + ttw_pkg::ADDR_W'(col);
   endfunction

   assign blank_cell = {text_color, ttw_pkg::SPACE_CODE};
   assign col_inc    = {1'b0, col_ff} + 1'b1;
   assign cmd_take   = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_pop);

   // command sequencer
   always_comb begin
      state_in       = state_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      sweep_in       = sweep_ff;
      mv_pend_in     = 1'b0;
      mv_addr_in     = mv_addr_ff;
      moved_in       = moved_ff;
      rsp_load       = 1'b0;
      rsp_moved_new  = 1'b0;
      rsp_data_new   = '0;
      rsp_rvalid_new = 1'b0;
      ram_we         = 1'b0;
      ram_waddr      = sweep_ff;
      ram_wdata      = blank_cell;
      ram_raddr      = cmd_link.cmd.addr;
      row_step       = 1'b0;
      row_inc        = {1'b0, row_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_link.valid && cmd_take) begin
               unique case (cmd_link.cmd.kind)
                  ttw_pkg::CMD_WRITE, ttw_pkg::CMD_NEWLINE: begin
                     if (cmd_link.cmd.kind == ttw_pkg::CMD_NEWLINE) begin
                        row_step = 1'b1;
                        col_in   = '0;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = cell_addr(row_ff, col_ff);
                        ram_wdata = {text_color, cmd_link.cmd.char_code};
                        // wrap at the end of the row
                        if (32'(col_inc) == ttw_pkg::COLUMNS) begin
                           row_step = 1'b1;
                           col_in   = '0;
                        end else begin
                           col_in = ttw_pkg::COL_W'(col_inc);
                        end
                     end
                     if (row_step) begin
                        row_inc = {1'b0, row_ff} + 1'b1;
                     end
                     if (32'(row_inc) >= ttw_pkg::ROWS) begin
                        row_inc = '0;
                     end
                     // reaching the last row scrolls the screen up
                     if (32'(row_inc) == ttw_pkg::ROWS - 1) begin
                        row_in   = ttw_pkg::ROW_W'(ttw_pkg::ROWS - 2);
                        moved_in = row_step;
                        sweep_in = '0;
                        state_in = ST_MOVE;
                     end else begin
                        row_in        = ttw_pkg::ROW_W'(row_inc);
                        rsp_load      = 1'b1;
                        rsp_moved_new = row_step;
                     end
                  end
                  ttw_pkg::CMD_CLEAR: begin
                     col_in   = '0;
                     row_in   = '0;
                     moved_in = 1'b0;
                     sweep_in = '0;
                     state_in = ST_BLANK;
                  end
                  ttw_pkg::CMD_READ: begin
                     ram_raddr = cmd_link.cmd.addr;
                     state_in  = ST_READ;
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_load       = 1'b1;
            rsp_data_new   = ram_rdata;
            rsp_rvalid_new = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_MOVE: begin
            // copy one cell up a row per cycle; each write uses the registered read data
            if (mv_pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = mv_addr_ff;
               ram_wdata = ram_rdata;
            end
            if (32'(sweep_ff) < ttw_pkg::MOVE_COUNT) begin
               ram_raddr  = sweep_ff + ttw_pkg::ADDR_W'(ttw_pkg::COLUMNS);
               mv_pend_in = 1'b1;
               mv_addr_in = sweep_ff;
               sweep_in   = sweep_ff + 1'b1;
            end else begin
               state_in = ST_BLANK;
            end
         end
         ST_BLANK: begin
            ram_we    = 1'b1;
            ram_waddr = sweep_ff;
            ram_wdata = blank_cell;
            if (32'(sweep_ff) == ttw_pkg::CELL_COUNT - 1) begin
               rsp_load      = 1'b1;
               rsp_moved_new = moved_ff;
               state_in      = ST_IDLE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         mv_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         mv_pend_ff <= mv_pend_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // sweep and result payload
   always_ff @(posedge clock) begin
      sweep_ff   <= sweep_in;
      mv_addr_ff <= mv_addr_in;
      moved_ff   <= moved_in;
      if (rsp_load) begin
         rsp_pos_ff    <= ttw_pkg::POS_W'(cell_addr(row_in, col_in));
         rsp_moved_ff  <= rsp_moved_new;
         rsp_data_ff   <= rsp_data_new;
         rsp_rvalid_ff <= rsp_rvalid_new;
      end
   end

   // screen store
   ttw_ram #(
      .WIDTH (ttw_pkg::CELL_W),
      .DEPTH (ttw_pkg::CELL_COUNT)
   ) u_screen (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_empty           = !rsp_valid_ff;
   assign rsp_cursor_position = rsp_pos_ff;
   assign rsp_cursor_moved    = rsp_moved_ff;
   assign rsp_cell_data       = rsp_data_ff;
   assign rsp_read_valid      = rsp_rvalid_ff;

endmodule
